@@ hw/rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and sequencer states of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 512;
    localparam int COUNT_W = 61;
    localparam int ROUND_W = 7;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 64;
    localparam int BYTE_W  = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [4:0]       hash_t;

    localparam hash_t INIT_HASH = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam word_t K_ROUND0 = 32'h5A827999;
    localparam word_t K_ROUND1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND3 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_GRP1 = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_GRP2 = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_GRP3 = 7'd60;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

    localparam logic [POS_W-1:0]  LAST_POS = 6'd63;
    localparam logic [POS_W-1:0]  LEN_POS  = 6'd56;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              shift_byte;
        logic [BYTE_W-1:0] byte_val;
        logic              advance;
    } sched_ctrl_t;

endpackage

@@ hw/rtl/sha1_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if import sha1_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              msg_end;

    modport source (output valid, data_byte, byte_present, msg_end, input ready);
    modport sink   (input valid, data_byte, byte_present, msg_end, output ready);
endinterface

interface sha1_out_if import sha1_pkg::*;;
    logic  valid;
    logic  ready;
    word_t digest_h0;
    word_t digest_h1;
    word_t digest_h2;
    word_t digest_h3;
    word_t digest_h4;

    modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                    input ready);
    modport sink   (input valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                    output ready);
endinterface

@@ hw/rtl/sha1_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_round
// One SHA-1 round: selects f and K by round group, updates a..e.
// ----------------------------------------------------------------------------
module sha1_round import sha1_pkg::*;
(
    input  hash_t               vars,
    input  word_t               w,
    input  logic [ROUND_W-1:0]  round,
    output hash_t               vars_next
);

    word_t a, b, c, d, e;
    word_t f, k, t;

    assign a = vars[0];
    assign b = vars[1];
    assign c = vars[2];
    assign d = vars[3];
    assign e = vars[4];

    always_comb
    begin
        if (round < ROUND_GRP1)
        begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
        end
        else if (round < ROUND_GRP2)
        begin
            f = b ^ c ^ d;
            k = K_ROUND1;
        end
        else if (round < ROUND_GRP3)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = K_ROUND3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w;
    end

    assign vars_next[0] = t;
    assign vars_next[1] = a;
    assign vars_next[2] = {b[1:0], b[31:2]};
    assign vars_next[3] = c;
    assign vars_next[4] = d;

endmodule

@@ hw/rtl/sha1_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer and message schedule: bytes shift in big-endian, then the
// sixteen-word window advances one word per round.
// ----------------------------------------------------------------------------
module sha1_sched import sha1_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output word_t       w_cur
);

    logic [BLOCK_W-1:0] block_reg, block_next;
    word_t              w0, w2, w8, w13, w_mix;

    assign w0    = block_reg[BLOCK_W-1 -: WORD_W];
    assign w2    = block_reg[BLOCK_W-1-2*WORD_W -: WORD_W];
    assign w8    = block_reg[BLOCK_W-1-8*WORD_W -: WORD_W];
    assign w13   = block_reg[BLOCK_W-1-13*WORD_W -: WORD_W];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_cur = w0;

    always_comb
    begin
        block_next = block_reg;
        if (ctrl.advance)
            block_next = {block_reg[BLOCK_W-WORD_W-1:0], w_mix[30:0], w_mix[31]};
        else if (ctrl.shift_byte)
            block_next = {block_reg[BLOCK_W-BYTE_W-1:0], ctrl.byte_val};
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

endmodule

@@ hw/rtl/sha1_hash_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine_top
// A byte that leaves its block unfilled is taken and ready stays high; a byte that fills
// a block holds ready low through all 80 rounds (on one shared round unit) and the add.
// Message end: one pad or length byte per cycle outside compressions, to the block end,
// a pad-state pass with no shift before the length, a compression per full block (one or
// two), then the done state and the registered digest. The round loop bounds throughput.
// Reset loads H0..H4, clears counters and drops any pending digest.
// ----------------------------------------------------------------------------
module sha1_hash_engine_top import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha1_in_if.sink     msg_in,
    sha1_out_if.source  digest_out
);

    state_t               state_reg, state_next;
    hash_t                chain_reg, chain_next;
    hash_t                work_reg, work_next;
    hash_t                round_vars;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   count_tmp;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 pad_first_reg, pad_first_next;
    logic                 pad_mode_reg, pad_mode_next;
    logic                 final_reg, final_next;
    logic                 out_valid_reg, out_valid_next;
    hash_t                out_hash_reg, out_hash_next;
    logic                 accept;
    sched_ctrl_t          sched_ctrl;
    word_t                w_cur;

    sha1_sched u_sched
    (
        .clk   (clk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    sha1_round u_round
    (
        .vars      (work_reg),
        .w         (w_cur),
        .round     (round_reg),
        .vars_next (round_vars)
    );

    assign msg_in.ready         = (state_reg == ST_IDLE);
    assign accept               = msg_in.valid && msg_in.ready;
    assign digest_out.valid     = out_valid_reg;
    assign digest_out.digest_h0 = out_hash_reg[0];
    assign digest_out.digest_h1 = out_hash_reg[1];
    assign digest_out.digest_h2 = out_hash_reg[2];
    assign digest_out.digest_h3 = out_hash_reg[3];
    assign digest_out.digest_h4 = out_hash_reg[4];

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        round_next     = round_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        pad_first_next = pad_first_reg;
        pad_mode_next  = pad_mode_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        sched_ctrl     = '0;
        count_tmp      = count_reg + COUNT_W'(msg_in.byte_present);

        if (out_valid_reg && digest_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (msg_in.byte_present)
                    begin
                        sched_ctrl.shift_byte = 1'b1;
                        sched_ctrl.byte_val   = msg_in.data_byte;
                        count_next            = count_tmp;
                        pos_next              = pos_reg + POS_W'(1);
                    end
                    if (msg_in.msg_end)
                    begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                        len_next       = {count_tmp, 3'b000};
                    end
                    if (msg_in.byte_present && pos_reg == LAST_POS)
                    begin
                        work_next  = chain_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                    else if (msg_in.msg_end)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                work_next          = round_vars;
                sched_ctrl.advance = 1'b1;
                round_next         = round_reg + ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (final_reg)
                    state_next = ST_DONE;
                else if (pad_mode_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                if (!pad_first_reg && pos_reg == LEN_POS)
                    state_next = ST_LEN;
                else
                begin
                    sched_ctrl.shift_byte = 1'b1;
                    sched_ctrl.byte_val   = pad_first_reg ? PAD_BYTE : '0;
                    pad_first_next        = 1'b0;
                    pos_next              = pos_reg + POS_W'(1);
                    if (pos_reg == LAST_POS)
                    begin
                        work_next  = chain_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_LEN:
            begin
                sched_ctrl.shift_byte = 1'b1;
                sched_ctrl.byte_val   = len_reg[LEN_W-1 -: BYTE_W];
                len_next              = {len_reg[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                pos_next              = pos_reg + POS_W'(1);
                if (pos_reg == LAST_POS)
                begin
                    final_next = 1'b1;
                    work_next  = chain_reg;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || digest_out.ready)
                begin
                    out_hash_next  = chain_reg;
                    out_valid_next = 1'b1;
                    chain_next     = INIT_HASH;
                    work_next      = '0;
                    round_next     = '0;
                    count_next     = '0;
                    pos_next       = '0;
                    pad_first_next = 1'b0;
                    pad_mode_next  = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= INIT_HASH;
            work_reg      <= '0;
            round_reg     <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            pad_first_reg <= 1'b0;
            pad_mode_reg  <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            round_reg     <= round_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            pad_first_reg <= pad_first_next;
            pad_mode_reg  <= pad_mode_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        out_hash_reg <= out_hash_next;
    end

endmodule

@@ hw/rtl/sha1_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks of the SHA-1 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker import sha1_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  msg_end,
    input logic  out_valid,
    input logic  out_ready,
    input word_t digest_h0,
    input word_t digest_h1,
    input word_t digest_h2,
    input word_t digest_h3,
    input word_t digest_h4
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("digest beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(digest_h0) && $stable(digest_h1) &&
        $stable(digest_h2) && $stable(digest_h3) && $stable(digest_h4))
        else $error("digest changed while stalled");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && msg_end |=> !in_ready)
        else $error("engine ready right after message end");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !msg_end |=> !$rose(out_valid))
        else $error("digest without message end");

endmodule

bind sha1_hash_engine_top sha1_checker u_sha1_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg_in.valid),
    .in_ready  (msg_in.ready),
    .msg_end   (msg_in.msg_end),
    .out_valid (digest_out.valid),
    .out_ready (digest_out.ready),
    .digest_h0 (digest_out.digest_h0),
    .digest_h1 (digest_out.digest_h1),
    .digest_h2 (digest_out.digest_h2),
    .digest_h3 (digest_out.digest_h3),
    .digest_h4 (digest_out.digest_h4)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// SHA-1 engine check: byte beats in, digest beats out, each digest compared
// word by word against an in-bench SHA-1 model of the byte stream or a known
// digest. Starts with known digests (empty message, "abc"), then random
// messages with lengths clustered around the padding boundaries, under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int MIN_ITEMS = 1000;
    localparam int MIN_MESSAGES = 48;
    localparam int DIR_ROWS = 14;

    localparam hash_t DIGEST_EMPTY = {32'hAFD80709, 32'h95601890, 32'h3255BFEF,
                                      32'h5E6B4B0D, 32'hDA39A3EE};
    localparam hash_t DIGEST_ABC   = {32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571,
                                      32'h4706816A, 32'hA9993E36};

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              present;
        logic              last;
        logic              typed;
        hash_t             digest;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sha1_in_if  msg_in ();
    sha1_out_if digest_out ();

    sha1_hash_engine_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .digest_out (digest_out)
    );

    hash_t             chain_state = INIT_HASH;
    logic [BYTE_W-1:0] blk_bytes [64];
    logic [COUNT_W-1:0] msg_bytes = '0;

    hash_t     pending_digests [$];
    stim_row_t dir_rows [DIR_ROWS];
    int        src_idle_pct = 10;
    int        snk_idle_pct = 66;
    int        items_sent = 0;
    int        messages_sent = 0;
    int        digests_seen = 0;
    int        mismatches = 0;
    int        stall_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        msg_in.valid = 1'b0;
        msg_in.data_byte = '0;
        msg_in.byte_present = 1'b0;
        msg_in.msg_end = 1'b0;
        digest_out.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        digest_out.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    function automatic void sha_compress();
        word_t w [16];
        word_t a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                t = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
                w[r%16] = {t[30:0], t[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_state[0] = chain_state[0] + a;
        chain_state[1] = chain_state[1] + b;
        chain_state[2] = chain_state[2] + c;
        chain_state[3] = chain_state[3] + d;
        chain_state[4] = chain_state[4] + e;
    endfunction

    function automatic bit digest_step(input logic [BYTE_W-1:0] data, input logic present,
                                       input logic last, output hash_t dig);
        logic [LEN_W-1:0] bit_len;
        int pos;
        dig = '0;
        if (present)
        begin
            blk_bytes[msg_bytes[POS_W-1:0]] = data;
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[POS_W-1:0] == '0)
                sha_compress();
        end
        if (!last)
            return 1'b0;
        bit_len = {msg_bytes, 3'b000};
        pos = msg_bytes[POS_W-1:0];
        blk_bytes[pos] = PAD_BYTE;
        pos = pos + 1;
        if (pos > LEN_POS)
        begin
            while (pos < 64)
            begin
                blk_bytes[pos] = '0;
                pos = pos + 1;
            end
            sha_compress();
            pos = 0;
        end
        while (pos < LEN_POS)
        begin
            blk_bytes[pos] = '0;
            pos = pos + 1;
        end
        for (int j = 0; j < 8; j++)
        begin
            blk_bytes[LEN_POS + j] = bit_len[63 - 8*j -: 8];
        end
        sha_compress();
        dig = chain_state;
        chain_state = INIT_HASH;
        msg_bytes = '0;
        return 1'b1;
    endfunction

    task automatic push_item(input stim_row_t row);
        hash_t dig;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            msg_in.valid <= 1'b0;
            @(negedge clk);
        end
        msg_in.valid <= 1'b1;
        msg_in.data_byte <= row.data;
        msg_in.byte_present <= row.present;
        msg_in.msg_end <= row.last;
        do
            @(posedge clk);
        while (!msg_in.ready);
        if (digest_step(row.data, row.present, row.last, dig))
        begin
            pending_digests.push_back(row.typed ? row.digest : dig);
            messages_sent++;
        end
        if (row.present || row.last)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        stim_row_t row;
        int len;
        int pick;
        int style;
        bit joined;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = $urandom_range(0, 20);
        else if (pick < 85)
        begin
            case ($urandom_range(0, 9))
                0: len = 55;
                1: len = 56;
                2: len = 57;
                3: len = 63;
                4: len = 64;
                5: len = 65;
                6: len = 119;
                7: len = 120;
                8: len = 127;
                default: len = 128;
            endcase
        end
        else
            len = $urandom_range(21, 200);
        style = $urandom_range(0, 9);
        joined = (len > 0) && $urandom_range(0, 1);
        row = '0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                row.data = BYTE_W'($urandom_range(0, 255));
                row.present = 1'b0;
                row.last = 1'b0;
                push_item(row);
            end
            if (style == 0)
                row.data = 8'h00;
            else if (style == 1)
                row.data = 8'hFF;
            else
                row.data = BYTE_W'($urandom_range(0, 255));
            row.present = 1'b1;
            row.last = joined && (i == len - 1);
            push_item(row);
        end
        if (!joined)
        begin
            row.data = BYTE_W'($urandom_range(0, 255));
            row.present = 1'b0;
            row.last = 1'b1;
            push_item(row);
        end
    endtask

    task automatic wait_drained();
        msg_in.valid <= 1'b0;
        @(negedge clk);
        while (pending_digests.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        hash_t exp_dig;
        word_t got [5];
        if (rst_n && digest_out.valid && digest_out.ready)
        begin
            got[0] = digest_out.digest_h0;
            got[1] = digest_out.digest_h1;
            got[2] = digest_out.digest_h2;
            got[3] = digest_out.digest_h3;
            got[4] = digest_out.digest_h4;
            digests_seen++;
            if (pending_digests.size() == 0)
            begin
                mismatches++;
                $display("%t unexpected digest beat: %h %h %h %h %h", $time,
                         got[0], got[1], got[2], got[3], got[4]);
            end
            else
            begin
                exp_dig = pending_digests.pop_front();
                for (int i = 0; i < 5; i++)
                begin
                    if (got[i] !== exp_dig[i])
                    begin
                        mismatches++;
                        $display("%t digest_h%0d expected %h got %h", $time, i,
                                 exp_dig[i], got[i]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_in.valid && msg_in.ready) || (digest_out.valid && digest_out.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%t watchdog: no beat for %0d cycles, %0d digests pending", $time,
                         stall_cycles, pending_digests.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        dir_rows = '{
            '{8'hA5, 1'b0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
            '{8'h61, 1'b1, 1'b0, 1'b0, '0},
            '{8'h62, 1'b1, 1'b0, 1'b0, '0},
            '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
            '{8'h61, 1'b1, 1'b0, 1'b0, '0},
            '{8'h62, 1'b1, 1'b0, 1'b0, '0},
            '{8'h63, 1'b1, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
            '{8'h00, 1'b1, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, 1'b0, '0},
            '{8'h5A, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
        };
        src_idle_pct = 10;
        snk_idle_pct = 66;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_item(dir_rows[i]);
        while (items_sent < MIN_ITEMS / 3)
            send_message();
        wait_drained();

        src_idle_pct = 66;
        snk_idle_pct = 10;
        while (items_sent < 2 * MIN_ITEMS / 3)
            send_message();
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (items_sent < MIN_ITEMS || messages_sent < MIN_MESSAGES)
            send_message();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d byte/end beats over %0d messages, lengths 0..200 incl. pad edges",
                 items_sent, messages_sent);
        $display("checked %0d digests under three source/sink idle mixes", digests_seen);
        if (mismatches == 0 && pending_digests.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
